### src/sha256_pkg.sv
`default_nettype none
package sha256_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned BlockWords = 16;
	localparam int unsigned Rounds = 64;
	localparam int unsigned CountW = 61;

	typedef struct packed {
		logic [7:0] data_byte;
		logic has_byte;
		logic end_of_message;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0] word_index;
		logic last_word;
	} out_beat_t;

	localparam logic [7:0][31:0] IV = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

	localparam logic [63:0][31:0] K = {
		32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
		32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
		32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
		32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
		32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
		32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
		32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
		32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
		32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
		32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
		32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
		32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
		32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
		32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
		32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
		32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage
`default_nettype wire

### src/sha256_ram.sv
`default_nettype none
module sha256_ram #(
	parameter int unsigned Width = 32,
	parameter int unsigned Depth = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] waddr,
	input wire logic [Width-1:0] wdata,
	input wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### src/sha256_message_hash.sv
// Byte beats: one per cycle while idle; a beat that completes a 64-byte block
// stalls input during load, 64 rounds on the block RAM word stream and add.
// End of message: pad sweep to the last block RAM word, one or two compressions,
// then eight digest beats, one per cycle while out_ready is high.
// Reset (arst_n low) loads the initial hash, clears count.
`default_nettype none
module sha256_message_hash (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire sha256_pkg::in_beat_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output sha256_pkg::out_beat_t out_data
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_COMP = 3'd1;
	localparam logic [2:0] ST_FIN = 3'd2;
	localparam logic [2:0] ST_PAD = 3'd3;
	localparam logic [2:0] ST_OUT = 3'd4;
	localparam int unsigned Depth = sha256_pkg::BlockWords;
	localparam int unsigned AW = $clog2(Depth);

	logic [2:0] state_q;
	logic [6:0] cnt_q;
	logic [sha256_pkg::CountW-1:0] bc_q, bc_nx;
	logic [23:0] word_q;
	logic [AW-1:0] widx_q;
	logic end_q, first_q, data_blk_q;
	logic [2:0] oidx_q;
	logic [7:0][31:0] hash_q, v_q;
	logic [15:0][31:0] win_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0] wdata, rdata, pad_word, w, t1, t2, s0, s1;
	logic [63:0] bit_len;
	logic lenblk, accept, two;
	logic [5:0] rnd;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign bc_nx = bc_q + 1'b1;
	assign bit_len = {bc_q, 3'b000};
	assign two = (bc_q[5:0] >= 6'd56);
	assign lenblk = !two || !first_q;
	assign raddr = cnt_q[AW-1:0];
	assign rnd = cnt_q[5:0] - 6'd1;

	always_comb begin
		pad_word = '0;
		if (first_q && widx_q == bc_q[5:2]) begin
			case (bc_q[1:0])
				2'd0: pad_word = 32'h8000_0000;
				2'd1: pad_word = {word_q[7:0], 8'h80, 16'h0};
				2'd2: pad_word = {word_q[15:0], 8'h80, 8'h0};
				default: pad_word = {word_q[23:0], 8'h80};
			endcase
		end else if (lenblk && widx_q == AW'(14)) begin
			pad_word = bit_len[63:32];
		end else if (lenblk && widx_q == AW'(15)) begin
			pad_word = bit_len[31:0];
		end
	end

	always_comb begin
		we = 1'b0;
		waddr = widx_q;
		wdata = pad_word;
		if (accept && in_data.has_byte && bc_q[1:0] == 2'd3) begin
			we = 1'b1;
			waddr = bc_q[5:2];
			wdata = {word_q, in_data.data_byte};
		end else if (state_q == ST_PAD) begin
			we = 1'b1;
		end
	end

	sha256_ram #(.Width(sha256_pkg::WordW), .Depth(Depth)) u_blk (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	always_comb begin
		s1 = sha256_pkg::rotr(win_q[14], 17) ^ sha256_pkg::rotr(win_q[14], 19)
			^ (win_q[14] >> 10);
		s0 = sha256_pkg::rotr(win_q[1], 7) ^ sha256_pkg::rotr(win_q[1], 18)
			^ (win_q[1] >> 3);
		w = (rnd < 6'd16) ? rdata : s1 + win_q[9] + s0 + win_q[0];
		t1 = v_q[7] + (sha256_pkg::rotr(v_q[4], 6) ^ sha256_pkg::rotr(v_q[4], 11)
			^ sha256_pkg::rotr(v_q[4], 25)) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ sha256_pkg::K[rnd] + w;
		t2 = (sha256_pkg::rotr(v_q[0], 2) ^ sha256_pkg::rotr(v_q[0], 13)
			^ sha256_pkg::rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk) begin
		if (accept && in_data.has_byte) begin
			word_q <= {word_q[15:0], in_data.data_byte};
		end
		if (state_q == ST_COMP) begin
			if (cnt_q == 7'd0) begin
				v_q <= hash_q;
			end else begin
				v_q <= {v_q[6:4], v_q[3] + t1, v_q[2:0], t1 + t2};
				win_q <= {w, win_q[15:1]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			bc_q <= '0;
			widx_q <= '0;
			end_q <= 1'b0;
			first_q <= 1'b0;
			data_blk_q <= 1'b0;
			oidx_q <= '0;
			hash_q <= sha256_pkg::IV;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						first_q <= 1'b1;
						end_q <= in_data.end_of_message;
						widx_q <= in_data.has_byte ? bc_nx[5:2] : bc_q[5:2];
						data_blk_q <= in_data.has_byte && (bc_nx[5:0] == 6'd0);
						if (in_data.has_byte) begin
							bc_q <= bc_nx;
							if (bc_nx[5:0] == 6'd0) begin
								state_q <= ST_COMP;
								cnt_q <= '0;
							end else if (in_data.end_of_message) begin
								state_q <= ST_PAD;
							end
						end else if (in_data.end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					widx_q <= widx_q + 1'b1;
					if (widx_q == AW'(Depth - 1)) begin
						state_q <= ST_COMP;
						cnt_q <= '0;
					end
				end
				ST_COMP: begin
					if (cnt_q == 7'(sha256_pkg::Rounds)) begin
						cnt_q <= '0;
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FIN: begin
					for (int i = 0; i < 8; i++) begin
						hash_q[i] <= hash_q[i] + v_q[i];
					end
					if (data_blk_q && end_q) begin
						// full data block done, end beat still needs its pad block
						data_blk_q <= 1'b0;
						first_q <= 1'b1;
						widx_q <= '0;
						state_q <= ST_PAD;
					end else if (!end_q) begin
						data_blk_q <= 1'b0;
						state_q <= ST_IDLE;
					end else if (lenblk) begin
						state_q <= ST_OUT;
						oidx_q <= '0;
					end else begin
						first_q <= 1'b0;
						widx_q <= '0;
						state_q <= ST_PAD;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						oidx_q <= oidx_q + 1'b1;
						if (oidx_q == 3'd7) begin
							hash_q <= sha256_pkg::IV;
							bc_q <= '0;
							end_q <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = (state_q == ST_OUT);
	assign out_data.digest_word = hash_q[oidx_q];
	assign out_data.word_index = oidx_q;
	assign out_data.last_word = (oidx_q == 3'd7);

`ifndef SYNTH
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !in_ready) else $error("input taken while busy");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 7'(sha256_pkg::Rounds)) else $error("round count overrun");
	a_out_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> end_q) else $error("digest without end of message");
	a_pad_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PAD |-> end_q) else $error("padding without end of message");
`endif
endmodule
`default_nettype wire

### test/sha256_message_hash_test.sv
`timescale 1ns / 1ps
`default_nettype none
module sha256_message_hash_test;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	sha256_pkg::in_beat_t in_data;
	logic out_valid;
	logic out_ready;
	sha256_pkg::out_beat_t out_data;

	sha256_message_hash dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	localparam logic [7:0][31:0] INIT_HASH = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};
	localparam logic [63:0][31:0] ROUND_CONST = {
		32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
		32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
		32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
		32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
		32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
		32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
		32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
		32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
		32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
		32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
		32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
		32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
		32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
		32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
		32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
		32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98};

	logic [31:0] run_hash [8];
	logic [7:0] msg_block [64];
	logic [60:0] msg_bytes;
	sha256_pkg::out_beat_t digest_q [$];
	bit failed;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_recv;

	function automatic logic [31:0] ror(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress_block();
		logic [31:0] w [16];
		logic [31:0] v [8];
		logic [31:0] wt, t1, t2, w2, w15;
		for (int i = 0; i < 8; i++) v[i] = run_hash[i];
		for (int r = 0; r < 64; r++) begin
			if (r < 16) begin
				wt = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
			end else begin
				w2 = w[(r-2) & 15];
				w15 = w[(r-15) & 15];
				wt = (ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10)) + w[(r-7) & 15]
					+ (ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3)) + w[r & 15];
			end
			w[r & 15] = wt;
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[r] + wt;
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) run_hash[i] += v[i];
	endtask

	task automatic absorb_beat(sha256_pkg::in_beat_t b);
		int pos;
		logic [63:0] bits;
		sha256_pkg::out_beat_t o;
		if (b.has_byte) begin
			msg_block[msg_bytes[5:0]] = b.data_byte;
			msg_bytes = msg_bytes + 61'd1;
			if (msg_bytes[5:0] == 6'd0) compress_block();
		end
		if (!b.end_of_message) return;
		pos = int'(msg_bytes[5:0]);
		msg_block[pos] = 8'h80;
		for (int i = pos + 1; i < 64; i++) msg_block[i] = '0;
		if (pos >= 56) begin
			compress_block();
			for (int i = 0; i < 56; i++) msg_block[i] = '0;
		end
		bits = {msg_bytes, 3'b000};
		for (int i = 0; i < 8; i++) msg_block[63-i] = bits[8*i +: 8];
		compress_block();
		for (int i = 0; i < 8; i++) begin
			o.digest_word = run_hash[i];
			o.word_index = 3'(i);
			o.last_word = (i == 7);
			digest_q.push_back(o);
			run_hash[i] = INIT_HASH[i];
		end
		msg_bytes = '0;
	endtask

	task automatic send_beat(logic [7:0] d, logic hb, logic eom);
		sha256_pkg::in_beat_t b;
		b.data_byte = d;
		b.has_byte = hb;
		b.end_of_message = eom;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
			while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		end
		in_valid <= 1;
		in_data <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		absorb_beat(b);
		@(negedge clk);
	endtask

	task automatic send_message(int len, bit last_with_byte);
		for (int i = 0; i < len; i++)
			send_beat(8'($urandom_range(255)), 1, last_with_byte && i == len - 1);
		if (!last_with_byte || len == 0) send_beat(8'($urandom_range(255)), 0, 1);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (digest_q.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic test_directed();
		send_message(0, 0);
		send_message(3, 1);
		send_beat(8'hff, 0, 0);
		send_beat(8'h00, 0, 0);
		send_message(55, 1);
		send_message(56, 1);
		send_message(63, 0);
		send_message(64, 1);
		send_message(64, 0);
		send_beat(8'h00, 1, 0);
		send_beat(8'hff, 1, 0);
		send_beat(8'haa, 0, 0);
		send_beat(8'h55, 1, 1);
		drain();
	endtask

	task automatic test_random(int items);
		int n;
		int len;
		n = 0;
		while (n < items) begin
			if ($urandom_range(9) == 0) begin
				send_beat(8'($urandom_range(255)), 0, 0);
			end else begin
				len = ($urandom_range(7) == 0) ? $urandom_range(130) : $urandom_range(12);
				send_message(len, 1'($urandom_range(1)));
				n += len + 1;
			end
		end
		drain();
	endtask

	task automatic test_backpressure();
		hold_recv = 1;
		send_idle_pct = 0;
		fork
			begin
				send_message(10, 1);
				send_message(10, 1);
				send_message(20, 0);
			end
			begin
				repeat (600) @(negedge clk);
				hold_recv = 0;
			end
		join
		drain();
	endtask

	always @(negedge clk)
		out_ready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk)
		if (arst_n && out_valid && out_ready) begin
			if (digest_q.size() == 0) begin
				$display("%0t: unexpected digest beat %h", $time, out_data);
				failed = 1;
			end else begin
				if (out_data !== digest_q[0])
					$display("%0t: expected word %h idx %0d last %b, got %h idx %0d last %b",
						$time, digest_q[0].digest_word, digest_q[0].word_index,
						digest_q[0].last_word, out_data.digest_word, out_data.word_index,
						out_data.last_word);
				if (out_data !== digest_q[0]) failed = 1;
				void'(digest_q.pop_front());
			end
		end

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("sha256_message_hash_test failed");
		$finish;
	end

	initial begin
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		out_ready = 0;
		hold_recv = 0;
		failed = 0;
		msg_bytes = '0;
		for (int i = 0; i < 8; i++) run_hash[i] = INIT_HASH[i];
		send_idle_pct = 13;
		recv_idle_pct = 81;
		repeat (10) @(negedge clk);
		arst_n = 1;
		test_directed();
		test_random(35);
		send_idle_pct = 81;
		recv_idle_pct = 13;
		test_random(30);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(30);
		test_backpressure();
		if (digest_q.size() != 0) failed = 1;
		if (!failed) begin
			$display("sha256_message_hash_test passed");
		end else begin
			$display("sha256_message_hash_test failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

### files.f
src/sha256_pkg.sv
src/sha256_ram.sv
src/sha256_message_hash.sv
test/sha256_message_hash_test.sv
